@@ hdl/mbalrc_pkg.sv @@
// ----------------------------------------------------------------------------
// Modbus ASCII LRC framer package
// Shared constants and character helpers for the Modbus ASCII framer.
// ----------------------------------------------------------------------------
package mbalrc_pkg;

   // Default depth of the transmit buffer that bounds one message.
   localparam int BUFFER_LEN_DEFAULT = 256;

   // Number of characters appended after the message body.
   localparam int TRAILER_LEN = 4;

   // Frame terminating characters.
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   // A decoded hex character: valid flag and digit value.
   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   // Decodes 0-9, A-F and a-f; anything else comes back invalid with value 0.
   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type d;
      d.valid = 1'b0;
      d.value = 4'h0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.valid = 1'b1;
         d.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.valid = 1'b1;
         d.value = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d.valid = 1'b1;
         d.value = 4'(c - 8'h57);
      end
      return d;
   endfunction

   // Encodes a nibble as an uppercase hex character.
   function automatic logic [7:0] hex_encode(input logic [3:0] n);
      logic [7:0] c;
      if (n < 4'd10) begin
         c = 8'h30 + {4'h0, n};
      end else begin
         c = 8'h37 + {4'h0, n};
      end
      return c;
   endfunction

endpackage

@@ hdl/modbus_ascii_frame_lrc_appender_unit.sv @@
// ----------------------------------------------------------------------------
// Modbus ASCII frame LRC appender
// Echoes a Modbus ASCII request and appends its LRC, CR and LF.
// ----------------------------------------------------------------------------
// Each request character is loaded into the result register and leaves it in
// the following cycle, so a message streams through at one character per
// clock while the result side keeps up. The first character (start colon) is
// not summed; later characters are paired into hex bytes and added to an 8-bit
// sum. After the beat marked last the block sends four more beats - the LRC as
// two uppercase hex characters, CR and LF (LF carries tlast) - and holds off
// the request side while the trailer sequencer issues them.
// rsp_tuser flags a message whose length plus four exceeds BUFFER_LEN.
module modbus_ascii_frame_lrc_appender_unit
   import mbalrc_pkg::*;
#(
   parameter int BUFFER_LEN = BUFFER_LEN_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // Request stream.
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tlast,   // in_last
   // Result stream.
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast,   // out_last
   output logic [0:0] rsp_tuser    // [0] too_long
);

   localparam int CNT_W = $clog2(BUFFER_LEN + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(BUFFER_LEN);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUFFER_LEN - TRAILER_LEN);

   // Trailer sequencer states.
   typedef enum logic [4:0] {
      TRL_IDLE = 5'b00001,
      TRL_HI   = 5'b00010,
      TRL_LO   = 5'b00100,
      TRL_CR   = 5'b01000,
      TRL_LF   = 5'b10000
   } trl_state_type;

   // Message state.
   logic             first_seen_ff, first_seen_in;
   logic             half_pair_ff, half_pair_in;
   logic [3:0]       high_nibble_ff, high_nibble_in;
   logic             pair_broken_ff, pair_broken_in;
   logic [7:0]       lrc_sum_ff, lrc_sum_in;
   logic [CNT_W-1:0] char_count_ff, char_count_in;

   // Trailer state.
   trl_state_type    trl_state_ff, trl_state_in;
   logic [7:0]       lrc_ff, lrc_in;
   logic             trl_long_ff, trl_long_in;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_long_ff, rsp_long_in;

   logic             slot_free;
   logic             req_fire;
   hex_digit_type    digit;
   logic [CNT_W-1:0] count_next;
   logic             too_long;
   logic [7:0]       sum_next;
   logic [7:0]       sum_final;

   // The result register can take a new beat when empty or being drained.
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (trl_state_ff == TRL_IDLE) && slot_free;
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_char_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_long_ff;

   // Character count and length check.
   assign count_next = (char_count_ff < CNT_MAX) ? char_count_ff + CNT_W'(1) : char_count_ff;
   assign too_long   = count_next > CNT_LIMIT;

   // Pair decoding and sum update for one character.
   always_comb begin
      digit          = hex_decode(req_tdata);
      first_seen_in  = first_seen_ff;
      half_pair_in   = half_pair_ff;
      high_nibble_in = high_nibble_ff;
      pair_broken_in = pair_broken_ff;
      sum_next       = lrc_sum_ff;
      priority if (!first_seen_ff) begin
         first_seen_in = 1'b1;
      end else if (!half_pair_ff) begin
         half_pair_in   = 1'b1;
         pair_broken_in = !digit.valid;
         high_nibble_in = digit.value;
      end else begin
         half_pair_in = 1'b0;
         if (!pair_broken_ff) begin
            if (digit.valid) begin
               sum_next = lrc_sum_ff + {high_nibble_ff, digit.value};
            end else begin
               sum_next = lrc_sum_ff + {4'h0, high_nibble_ff};
            end
         end
         pair_broken_in = 1'b0;
         high_nibble_in = 4'h0;
      end
      // A lone trailing digit counts as the value of its pair.
      if (half_pair_in && !pair_broken_in) begin
         sum_final = sum_next + {4'h0, high_nibble_in};
      end else begin
         sum_final = sum_next;
      end
   end

   // Next values of the message, trailer and result registers.
   always_comb begin
      lrc_sum_in    = lrc_sum_ff;
      char_count_in = char_count_ff;
      trl_state_in  = trl_state_ff;
      lrc_in        = lrc_ff;
      trl_long_in   = trl_long_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_long_in   = rsp_long_ff;
      if (slot_free) begin
         rsp_valid_in = 1'b0;
         rsp_last_in  = 1'b0;
         rsp_long_in  = trl_long_ff;
         unique case (trl_state_ff)
            TRL_IDLE: begin
               if (req_fire) begin
                  rsp_valid_in  = 1'b1;
                  rsp_char_in   = req_tdata;
                  rsp_long_in   = too_long;
                  lrc_sum_in    = sum_next;
                  char_count_in = count_next;
                  if (req_tlast) begin
                     trl_state_in  = TRL_HI;
                     lrc_in        = 8'h00 - sum_final;
                     trl_long_in   = too_long;
                     lrc_sum_in    = 8'h00;
                     char_count_in = '0;
                  end
               end
            end
            TRL_HI: begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = hex_encode(lrc_ff[7:4]);
               trl_state_in = TRL_LO;
            end
            TRL_LO: begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = hex_encode(lrc_ff[3:0]);
               trl_state_in = TRL_CR;
            end
            TRL_CR: begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_CR;
               trl_state_in = TRL_LF;
            end
            TRL_LF: begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_LF;
               rsp_last_in  = 1'b1;
               trl_state_in = TRL_IDLE;
            end
            default: begin
               trl_state_in = TRL_IDLE;
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_seen_ff  <= 1'b0;
         half_pair_ff   <= 1'b0;
         high_nibble_ff <= 4'h0;
         pair_broken_ff <= 1'b0;
         lrc_sum_ff     <= 8'h00;
         char_count_ff  <= '0;
         trl_state_ff   <= TRL_IDLE;
         rsp_valid_ff   <= 1'b0;
         rsp_last_ff    <= 1'b0;
      end else begin
         lrc_sum_ff    <= lrc_sum_in;
         char_count_ff <= char_count_in;
         trl_state_ff  <= trl_state_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_last_ff   <= rsp_last_in;
         if (req_fire) begin
            if (req_tlast) begin
               first_seen_ff  <= 1'b0;
               half_pair_ff   <= 1'b0;
               high_nibble_ff <= 4'h0;
               pair_broken_ff <= 1'b0;
            end else begin
               first_seen_ff  <= first_seen_in;
               half_pair_ff   <= half_pair_in;
               high_nibble_ff <= high_nibble_in;
               pair_broken_ff <= pair_broken_in;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      lrc_ff      <= lrc_in;
      trl_long_ff <= trl_long_in;
      rsp_char_ff <= rsp_char_in;
      rsp_long_ff <= rsp_long_in;
   end

   // The final request beat starts the trailer with its echo on the output.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> (trl_state_ff == TRL_HI && rsp_valid_ff))
      else $error("trailer did not start after the final request beat");

   // A delivered closing beat with no new request beat beside it leaves the
   // framer idle with its message state clear.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast && !req_fire) |=>
         (trl_state_ff == TRL_IDLE && !first_seen_ff && lrc_sum_ff == 8'h00))
      else $error("framer not cleared after the closing beat");

   // Only the LF beat closes a frame.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata == CHAR_LF))
      else $error("tlast on a beat other than LF");

endmodule

@@ dv/modbus_ascii_frame_lrc_appender_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Modbus ASCII frame LRC appender testbench
// Streams Modbus ASCII requests into the framer and checks every echoed
// character and every trailer beat (LRC digits, CR, LF) against a predictor
// kept in a scoreboard, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module modbus_ascii_frame_lrc_appender_unit_tb;
   import mbalrc_pkg::*;

   localparam int BUF_LEN       = BUFFER_LEN_DEFAULT;
   localparam int RANDOM_ITEMS  = 110;
   localparam int WATCHDOG_MAX  = 1000;
   localparam int DRAIN_CYCLES  = 8;

   typedef logic [7:0] char_type;

   // One character leaving the block, as the predictor sees it.
   typedef struct {
      char_type ch;
      logic     last;
      logic     too_long;
   } frame_beat_type;

   // Ways in which the receiver holds off the result stream.
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_RUNS
   } stall_mode_type;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts the framed output and checks each result beat.
   // -------------------------------------------------------------------------
   class lrc_frame_scoreboard;
      bit             start_taken;
      bit             digit_held;
      bit             held_not_hex;
      logic [7:0]     held_value;
      logic [7:0]     byte_sum;
      int unsigned    msg_length;
      frame_beat_type pending_beats[$];
      int             errors;

      function new();
         clear_message();
         errors = 0;
      endfunction

      function void clear_message();
         start_taken  = 1'b0;
         digit_held   = 1'b0;
         held_not_hex = 1'b0;
         held_value   = 8'h00;
         byte_sum     = 8'h00;
         msg_length   = 0;
      endfunction

      // Returns the digit value, or -1 for anything that is not a hex digit.
      function int hex_value(char_type c);
         if (c >= "0" && c <= "9") return int'(c) - int'("0");
         if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
         if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
         return -1;
      endfunction

      function char_type nibble_char(logic [3:0] n);
         if (n < 4'd10) return 8'h30 + {4'h0, n};
         return 8'h37 + {4'h0, n};
      endfunction

      function void push_beat(char_type ch, logic last, logic tl);
         frame_beat_type b;
         b.ch       = ch;
         b.last     = last;
         b.too_long = tl;
         pending_beats.push_back(b);
      endfunction

      // Notes one accepted request beat and queues the beats it causes.
      function void note_char(char_type c, logic last);
         logic       tl;
         int         d;
         logic [7:0] lrc;
         if (msg_length < BUF_LEN) msg_length++;
         tl = (msg_length + TRAILER_LEN) > BUF_LEN;

         // The start character is passed through unsummed; the rest pair up.
         if (!start_taken) begin
            start_taken = 1'b1;
         end else if (!digit_held) begin
            d = hex_value(c);
            digit_held   = 1'b1;
            held_not_hex = (d < 0);
            held_value   = (d < 0) ? 8'h00 : 8'(d);
         end else begin
            digit_held = 1'b0;
            if (!held_not_hex) begin
               d = hex_value(c);
               if (d < 0) byte_sum = byte_sum + held_value;
               else       byte_sum = byte_sum + ((held_value << 4) | 8'(d));
            end
            held_not_hex = 1'b0;
            held_value   = 8'h00;
         end
         push_beat(c, 1'b0, tl);

         // End of message: a lone digit still counts, then the trailer.
         if (last) begin
            if (digit_held && !held_not_hex) byte_sum = byte_sum + held_value;
            lrc = 8'h00 - byte_sum;
            push_beat(nibble_char(lrc[7:4]), 1'b0, tl);
            push_beat(nibble_char(lrc[3:0]), 1'b0, tl);
            push_beat(CHAR_CR, 1'b0, tl);
            push_beat(CHAR_LF, 1'b1, tl);
            clear_message();
         end
      endfunction

      // Compares one accepted result beat with the oldest prediction.
      function void check_beat(char_type ch, logic last, logic tl);
         frame_beat_type b;
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected result beat: char %h last %b too_long %b",
                     $time, ch, last, tl);
            errors++;
            return;
         end
         b = pending_beats.pop_front();
         if (ch !== b.ch) begin
            $display("%0t: out_char mismatch: expected %h, got %h", $time, b.ch, ch);
            errors++;
         end
         if (last !== b.last) begin
            $display("%0t: out_last mismatch: expected %b, got %b", $time, b.last, last);
            errors++;
         end
         if (tl !== b.too_long) begin
            $display("%0t: too_long mismatch: expected %b, got %b",
                     $time, b.too_long, tl);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and block under test.
   // -------------------------------------------------------------------------
   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic [0:0] rsp_tuser;

   lrc_frame_scoreboard frame_sb = new();
   stall_mode_type      stall_mode = STALL_NONE;
   bit                  sender_gaps = 1'b0;
   int                  burst_left = 0;
   int                  stall_run = 0;
   logic                stall_level = 1'b1;
   int                  idle_cycles = 0;

   modbus_ascii_frame_lrc_appender_unit #(
      .BUFFER_LEN (BUF_LEN)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver readiness follows the current stall mode.
   always @(posedge clock) begin
      case (stall_mode)
         STALL_NONE: begin
            rsp_tready <= 1'b1;
         end
         STALL_RANDOM: begin
            rsp_tready <= ($urandom_range(0, 2) != 0);
         end
         default: begin
            if (stall_run == 0) begin
               stall_run   = $urandom_range(1, 8);
               stall_level = ~stall_level;
            end
            stall_run--;
            rsp_tready <= stall_level;
         end
      endcase
   end

   // Monitor: notes accepted requests before checking results, and watches
   // for a stretch with no beat accepted on either side.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) frame_sb.note_char(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) frame_sb.check_beat(rsp_tdata, rsp_tlast, rsp_tuser[0]);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX) begin
               $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_MAX);
               $display("** modbus_ascii_frame_lrc_appender_unit: FAILED **");
               $finish;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus tasks.
   // -------------------------------------------------------------------------

   // Drives one request beat, inserting a gap between bursts when enabled.
   task automatic send_char(input char_type c, input logic last);
      if (sender_gaps && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left > 0) burst_left--;
   endtask

   task automatic send_message(input char_type chars[$]);
      foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
   endtask

   task automatic send_text(input string s);
      char_type chars[$];
      for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
      send_message(chars);
   endtask

   // A hex digit character, letters in either case.
   function automatic char_type random_hex_char();
      logic [3:0] n;
      char_type   c;
      n = 4'($urandom_range(0, 15));
      c = (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h37 + {4'h0, n};
      if (n >= 4'd10 && $urandom_range(0, 1) == 1) c = c + 8'h20;
      return c;
   endfunction

   // A start colon followed by hex digits, nchars characters in all.
   task automatic make_request(output char_type chars[$], input int unsigned nchars);
      chars = {8'h3A};
      while (chars.size() < nchars) chars.push_back(random_hex_char());
   endtask

   task automatic pick_idling();
      stall_mode  = stall_mode_type'($urandom_range(0, 2));
      sender_gaps = ($urandom_range(0, 1) == 1);
   endtask

   // -------------------------------------------------------------------------
   // Test sequence.
   // -------------------------------------------------------------------------
   initial begin
      char_type    msg[$];
      int unsigned random_items;
      int unsigned kind;
      int unsigned idx;

      random_items = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed messages with no idling on either side.
      send_text(":");                  // start character alone
      send_text(":01FF");              // sum wraps past 255
      send_text(":ab9");               // lowercase pair, lone trailing digit
      send_text(":G1");                // pair opened by a non-hex character
      msg = {8'h3A, "1", 8'h00};       // hex digit then a zero character
      send_message(msg);
      msg = {8'hFF, "7", "f"};         // start is not a colon, top code value
      send_message(msg);
      send_text(":Z");                 // lone trailing non-hex character

      // Random messages: mostly well-formed, some broken, some noise.
      while (random_items < RANDOM_ITEMS) begin
         pick_idling();
         kind = $urandom_range(0, 7);
         make_request(msg, $urandom_range(1, 14));
         if (kind == 5) begin
            idx = $urandom_range(0, msg.size() - 1);
            msg[idx] = char_type'($urandom_range(0, 255));
         end else if (kind >= 6) begin
            msg.delete();
            repeat ($urandom_range(1, 10)) msg.push_back(char_type'($urandom_range(0, 255)));
         end
         random_items += msg.size();
         send_message(msg);
      end

      // Drain: wait for every predicted beat, then let the block settle.
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      while (frame_sb.pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (frame_sb.errors == 0 && frame_sb.pending_beats.size() == 0) begin
         $display("** modbus_ascii_frame_lrc_appender_unit: PASSED **");
      end else begin
         $display("** modbus_ascii_frame_lrc_appender_unit: FAILED **");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/mbalrc_pkg.sv
hdl/modbus_ascii_frame_lrc_appender_unit.sv
dv/modbus_ascii_frame_lrc_appender_unit_tb.sv
